### rtl/ecfl_pkg.sv
// ----------------------------------------------------------------------------
// ecfl_pkg: shared types and constants of the Euler CFL number block
// Field widths, status codes and the divide-by-five reciprocal.
// ----------------------------------------------------------------------------
package ecfl_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int HTS_W         = 31;
  localparam int IN_FIELDS     = 6;
  localparam int IN_W          = DATA_W * IN_FIELDS;
  localparam int OUT_DATA_W    = 32;
  localparam int STAT_W        = 2;
  // width of m^2 (|m| <= 2^31, so the square stays below 2^63)
  localparam int SQ_W          = 2 * DATA_W - 1;

  localparam logic [HTS_W-1:0]  CFL_MAX = {HTS_W{1'b1}};
  // floor(x / 5) == (x * RECIP5) >> 34 for every 32-bit x
  localparam logic [DATA_W-1:0] RECIP5  = 32'hCCCC_CCCD;
  localparam int RECIP5_SHIFT = 34;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_DENSITY   = 2'd1,
    STAT_SPACING   = 2'd2,
    STAT_SATURATED = 2'd3
  } stat_t;

endpackage

### rtl/ecfl_div.sv
// ----------------------------------------------------------------------------
// ecfl_div: pipelined restoring divider
// One quotient bit per register stage; side data travels with each request.
// ----------------------------------------------------------------------------
module ecfl_div #(
  parameter int NW = 63,
  parameter int DW = 33,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          v [1:NW];
  logic [DW-1:0] r [1:NW];
  logic [NW-1:0] q [1:NW];
  logic [DW-1:0] d [1:NW];
  logic [SW-1:0] s [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          fit;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = in_num;
      assign d_in = in_den;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = v[k];
      assign r_in = r[k];
      assign q_in = q[k];
      assign d_in = d[k];
      assign s_in = s[k];
    end

    // shift in the next numerator bit, trial subtract
    assign t    = {r_in, q_in[NW-1]};
    assign diff = t - {1'b0, d_in};
    assign fit  = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v_in;
        r[k+1] <= fit ? diff[DW-1:0] : t[DW-1:0];
        q[k+1] <= {q_in[NW-2:0], fit};
        d[k+1] <= d_in;
        s[k+1] <= s_in;
      end
    end
  end

  assign out_valid = v[NW];
  assign out_quo   = q[NW];
  assign out_side  = s[NW];

endmodule

### rtl/ecfl_sqrt.sv
// ----------------------------------------------------------------------------
// ecfl_sqrt: pipelined floor square root
// One root bit per register stage, digit-by-digit restoring method.
// ----------------------------------------------------------------------------
module ecfl_sqrt #(
  parameter int NW = 65,
  parameter int SW = 1,
  localparam int R = (NW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [R-1:0]  out_root,
  output logic [SW-1:0] out_side
);

  localparam int RW = R + 2;
  localparam int AW = 2 * R;

  logic          v    [1:R];
  logic [RW-1:0] rem  [1:R];
  logic [R-1:0]  root [1:R];
  logic [AW-1:0] rad  [1:R];
  logic [SW-1:0] s    [1:R];

  for (genvar k = 0; k < R; k++) begin : g_step
    logic          v_in;
    logic [RW-1:0] rem_in;
    logic [R-1:0]  root_in;
    logic [AW-1:0] rad_in;
    logic [SW-1:0] s_in;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = AW'(in_rad);
      assign s_in    = in_side;
    end else begin : g_next
      assign v_in    = v[k];
      assign rem_in  = rem[k];
      assign root_in = root[k];
      assign rad_in  = rad[k];
      assign s_in    = s[k];
    end

    // bring down two radicand bits, try root*4+1
    assign t     = {rem_in, rad_in[AW-1 -: 2]};
    assign trial = (RW + 2)'({root_in, 2'b01});
    assign diff  = t - trial;
    assign fit   = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1]    <= v_in;
        rem[k+1]  <= fit ? diff[RW-1:0] : t[RW-1:0];
        root[k+1] <= {root_in[R-2:0], fit};
        rad[k+1]  <= {rad_in[AW-3:0], 2'b00};
        s[k+1]    <= s_in;
      end
    end
  end

  assign out_valid = v[R];
  assign out_root  = root[R];
  assign out_side  = s[R];

endmodule

### rtl/ecfl_skid.sv
// ----------------------------------------------------------------------------
// ecfl_skid: output register with one skid entry
// Ready toward the pipeline comes from a register only.
// ----------------------------------------------------------------------------
module ecfl_skid #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         buf_valid;
  logic [W-1:0] buf_data;

  assign in_ready = !buf_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      buf_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (buf_valid) begin
        out_data  <= buf_data;
        buf_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_data  <= in_data;
      end
    end else if (in_valid && in_ready) begin
      // hold the request aside while the output waits
      buf_data  <= in_data;
      buf_valid <= 1'b1;
    end
  end

endmodule

### rtl/euler_cfl_number.sv
// ----------------------------------------------------------------------------
// euler_cfl_number: CFL number of one 1-D Euler solution element
//
// Usage:
//   Slave stream s_*: one request per element, tdata holds density, momentum,
//   total energy, left, centre and right position (signed Q16.16, 32 bits each,
//   density in the lowest bits). Master stream m_*: one request per element,
//   tdata[30:0] the CFL number, tuser the status (ok, non-positive density,
//   non-positive spacing, saturated). cfg_wr_en/cfg_wr_data load the half
//   time step; write it only while no element is in flight.
// Throughput: one element per cycle, sustained while m_tready is high.
// Path: from s_ accept to m_tvalid an element passes the three bit-per-stage
//   dividers (kinetic energy and velocity side by side, sound speed squared,
//   final quotient) and the bit-per-stage square root.
// Reset: rst clears all valid bits and the half time step; no item survives.
// Stall: while m_tready is low the output holds; one more result goes into a
//   skid entry, then s_tready drops and the whole pipeline freezes in place.
// ----------------------------------------------------------------------------
module euler_cfl_number #(
  parameter int FRACTION_BITS = ecfl_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ecfl_pkg::HTS_W-1:0]       cfg_wr_data,   // half_time_step
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // density, momentum, total_energy, pos_left, pos_centre, pos_right
  input  logic [ecfl_pkg::IN_W-1:0]        s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ecfl_pkg::OUT_DATA_W-1:0]  m_tdata,       // cfl_value, zero pad
  output logic [ecfl_pkg::STAT_W-1:0]      m_tuser        // status
);

  import ecfl_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int UW  = DATA_W + F;          // velocity term width
  localparam int N2W = DATA_W + 1 + 2 * F;  // 7p << 2F
  localparam int D2W = DATA_W + 2;          // 5 * rho
  localparam int RTW = (N2W + 1) / 2;       // sound speed width
  localparam int WW  = DATA_W + 1 + F;      // wave speed width
  localparam int WHW = WW - DATA_W;         // upper slice of wave speed
  localparam int PLW = HTS_W + DATA_W;      // low partial product
  localparam int PHW = HTS_W + WHW;         // high partial product
  localparam int PW  = HTS_W + WW;          // full product
  localparam int RES_W = STAT_W + HTS_W;

  typedef struct packed {
    logic [DATA_W-1:0] rho;
    logic [DATA_W-1:0] ene;
    logic [DATA_W-1:0] dx;
  } ke_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] dx;
    stat_t             code;
    logic [UW-1:0]     u;
  } c_side_t;

  // global advance: the skid entry is free
  logic en;

  logic [HTS_W-1:0] half_time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_time_step <= '0;
    end else if (cfg_wr_en) begin
      half_time_step <= cfg_wr_data;
    end
  end

  // ---- input unpack and checks ----
  logic signed [DATA_W-1:0] rho_in, mom_in, ene_in, xl_in, xc_in, xr_in;
  logic signed [DATA_W:0]   dxp, dxn, dx_min;
  logic [DATA_W-1:0]        am_in;
  stat_t                    code_in;

  assign rho_in = s_tdata[0*DATA_W +: DATA_W];
  assign mom_in = s_tdata[1*DATA_W +: DATA_W];
  assign ene_in = s_tdata[2*DATA_W +: DATA_W];
  assign xl_in  = s_tdata[3*DATA_W +: DATA_W];
  assign xc_in  = s_tdata[4*DATA_W +: DATA_W];
  assign xr_in  = s_tdata[5*DATA_W +: DATA_W];

  assign dxp    = {xr_in[DATA_W-1], xr_in} - {xc_in[DATA_W-1], xc_in};
  assign dxn    = {xc_in[DATA_W-1], xc_in} - {xl_in[DATA_W-1], xl_in};
  assign dx_min = (dxp < dxn) ? dxp : dxn;
  // two's complement negate; the most negative value maps to 2^31 unsigned
  assign am_in  = mom_in[DATA_W-1] ? (~mom_in + 1'b1) : mom_in;

  always_comb begin
    if (rho_in[DATA_W-1] || rho_in == '0) begin
      code_in = STAT_DENSITY;
    end else if (dx_min[DATA_W] || dx_min == '0) begin
      code_in = STAT_SPACING;
    end else begin
      code_in = STAT_OK;
    end
  end

  // ---- stage 1: register the element ----
  logic              v1;
  logic [DATA_W-1:0] rho1, am1, ene1, dx1;
  stat_t             code1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1    <= s_tvalid;
      rho1  <= rho_in;
      am1   <= am_in;
      ene1  <= ene_in;
      dx1   <= dx_min[DATA_W-1:0];
      code1 <= code_in;
    end
  end

  // ---- stage 2: square the momentum ----
  logic              v2;
  logic [SQ_W-1:0]   amsq2;
  logic [DATA_W-1:0] rho2, am2, ene2, dx2;
  stat_t             code2;
  logic [2*DATA_W-1:0] amsq_full;

  assign amsq_full = am1 * am1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2    <= v1;
      amsq2 <= amsq_full[SQ_W-1:0];
      rho2  <= rho1;
      am2   <= am1;
      ene2  <= ene1;
      dx2   <= dx1;
      code2 <= code1;
    end
  end

  // ---- kinetic energy m^2/(2 rho) and velocity |m|/rho side by side ----
  ke_side_t          ke_side_in, ke_side_out;
  logic              ke_v, u_v;
  logic [SQ_W-1:0]   ke_q, u_q;
  logic [STAT_W-1:0] code_u;

  assign ke_side_in = '{rho: rho2, ene: ene2, dx: dx2};

  ecfl_div #(.NW(SQ_W), .DW(DATA_W + 1), .SW($bits(ke_side_t))) u_div_ke (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .in_num   (amsq2),
    .in_den   ({rho2, 1'b0}),
    .in_side  (ke_side_in),
    .out_valid(ke_v),
    .out_quo  (ke_q),
    .out_side (ke_side_out)
  );

  ecfl_div #(.NW(SQ_W), .DW(DATA_W + 1), .SW(STAT_W)) u_div_u (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .in_num   (SQ_W'(am2) << F),
    .in_den   ({1'b0, rho2}),
    .in_side  (code2),
    .out_valid(u_v),
    .out_quo  (u_q),
    .out_side (code_u)
  );

  // ---- stage 3: pressure numerator 2*(E - ke), clamped at zero ----
  logic                     v3;
  logic [DATA_W-1:0]        x3, rho3, dx3;
  stat_t                    code3;
  logic [UW-1:0]            u3;
  logic signed [DATA_W-1:0] ke_lo;
  logic signed [DATA_W-1:0] ene_d;
  logic [DATA_W-1:0]        ediff;
  logic                     d_pos;

  assign ke_lo = {1'b0, ke_q[DATA_W-2:0]};
  assign ene_d = ke_side_out.ene;
  assign d_pos = (ke_q[SQ_W-1:DATA_W-1] == '0) && (ene_d > ke_lo);
  assign ediff = ene_d - ke_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3    <= ke_v && u_v;
      x3    <= d_pos ? {ediff[DATA_W-2:0], 1'b0} : '0;
      rho3  <= ke_side_out.rho;
      dx3   <= ke_side_out.dx;
      code3 <= stat_t'(code_u);
      u3    <= u_q[UW-1:0];
    end
  end

  // ---- stage 4: divide by five through the reciprocal ----
  logic                v4;
  logic [2*DATA_W-1:0] prod4;
  logic [DATA_W-1:0]   rho4, dx4;
  stat_t               code4;
  logic [UW-1:0]       u4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4    <= v3;
      prod4 <= x3 * RECIP5;
      rho4  <= rho3;
      dx4   <= dx3;
      code4 <= code3;
      u4    <= u3;
    end
  end

  // ---- stage 5: 7p << 2F over 5 rho ----
  localparam int PQW = 2 * DATA_W - RECIP5_SHIFT;
  logic             v5;
  logic [N2W-1:0]   num5;
  logic [D2W-1:0]   den5;
  logic [DATA_W-1:0] dx5;
  stat_t            code5;
  logic [UW-1:0]    u5;
  logic [PQW-1:0]   p4;
  logic [PQW+2:0]   p7;

  assign p4 = prod4[2*DATA_W-1:RECIP5_SHIFT];
  assign p7 = {p4, 3'b000} - {3'b000, p4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5    <= v4;
      num5  <= N2W'(p7) << (2 * F);
      den5  <= {rho4, 2'b00} + {2'b00, rho4};
      dx5   <= dx4;
      code5 <= code4;
      u5    <= u4;
    end
  end

  // ---- sound speed squared and its root ----
  c_side_t        c_side_in, c_side_div, c_side_out;
  logic           c2_v, c_v;
  logic [N2W-1:0] c2_q;
  logic [RTW-1:0] c_root;

  assign c_side_in = '{dx: dx5, code: code5, u: u5};

  ecfl_div #(.NW(N2W), .DW(D2W), .SW($bits(c_side_t))) u_div_c2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .in_num   (num5),
    .in_den   (den5),
    .in_side  (c_side_in),
    .out_valid(c2_v),
    .out_quo  (c2_q),
    .out_side (c_side_div)
  );

  ecfl_sqrt #(.NW(N2W), .SW($bits(c_side_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c2_v),
    .in_rad   (c2_q),
    .in_side  (c_side_div),
    .out_valid(c_v),
    .out_root (c_root),
    .out_side (c_side_out)
  );

  // ---- stage 6: wave speed ----
  logic              v6;
  logic [WW-1:0]     w6;
  logic [DATA_W-1:0] dx6;
  stat_t             code6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6    <= c_v;
      w6    <= WW'(c_root) + WW'(c_side_out.u);
      dx6   <= c_side_out.dx;
      code6 <= c_side_out.code;
    end
  end

  // ---- stage 7: partial products of dt/2 * w ----
  logic              v7;
  logic [PLW-1:0]    plo7;
  logic [PHW-1:0]    phi7;
  logic [DATA_W-1:0] dx7;
  stat_t             code7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7    <= v6;
      plo7  <= PLW'(half_time_step) * PLW'(w6[DATA_W-1:0]);
      phi7  <= PHW'(half_time_step) * PHW'(w6[WW-1:DATA_W]);
      dx7   <= dx6;
      code7 <= code6;
    end
  end

  // ---- stage 8: sum the partial products ----
  logic              v8;
  logic [PW-1:0]     prod8;
  logic [DATA_W-1:0] dx8;
  stat_t             code8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8    <= v7;
      prod8 <= {phi7, {DATA_W{1'b0}}} + PW'(plo7);
      dx8   <= dx7;
      code8 <= code7;
    end
  end

  // ---- CFL quotient over the smaller half spacing ----
  logic              q_v;
  logic [PW-1:0]     cfl_q;
  logic [STAT_W-1:0] code9;

  ecfl_div #(.NW(PW), .DW(DATA_W), .SW(STAT_W)) u_div_cfl (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v8),
    .in_num   (prod8),
    .in_den   (dx8),
    .in_side  (code8),
    .out_valid(q_v),
    .out_quo  (cfl_q),
    .out_side (code9)
  );

  // ---- saturate, apply the status, hand to the output register ----
  logic             sat;
  logic [HTS_W-1:0] cfl_res;
  stat_t            stat_res;
  logic [RES_W-1:0] res_out;

  assign sat = (cfl_q[PW-1:HTS_W] != '0);

  always_comb begin
    if (code9 != STAT_OK) begin
      cfl_res  = '0;
      stat_res = stat_t'(code9);
    end else if (sat) begin
      cfl_res  = CFL_MAX;
      stat_res = STAT_SATURATED;
    end else begin
      cfl_res  = cfl_q[HTS_W-1:0];
      stat_res = STAT_OK;
    end
  end

  ecfl_skid #(.W(RES_W)) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_v),
    .in_ready (en),
    .in_data  ({stat_res, cfl_res}),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (res_out)
  );

  assign s_tready = en;
  assign m_tdata  = OUT_DATA_W'(res_out[HTS_W-1:0]);
  assign m_tuser  = res_out[RES_W-1:HTS_W];

  // ---- assertions ----
  // back pressure only ever comes from a waiting result
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_DENSITY || m_tuser == STAT_SPACING)
      |-> m_tdata == '0)
    else $error("flagged element carries a nonzero CFL value");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STAT_SATURATED |-> m_tdata == OUT_DATA_W'(CFL_MAX))
    else $error("saturated result is not the maximum");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

endmodule

### bench/tb_euler_cfl_number.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_cfl_number: self-checking bench for the Euler CFL number block
// Feeds solution elements through the request stream and predicts each CFL
// number and status with wide integer arithmetic. It compares every result
// in order and changes the half time step only between phases, while idle.
// ----------------------------------------------------------------------------
module tb_euler_cfl_number;
  import ecfl_pkg::*;

  localparam int FB         = FRAC_BITS_DEF;
  localparam int DRAIN_CYC  = 400;       // comfortably above the pipeline latency
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_ITEMS = 272;

  typedef struct packed {
    logic signed [31:0] rho, mom, ene, xl, xc, xr;
  } elem_t;

  typedef struct packed {
    logic [HTS_W-1:0] cfl;
    stat_t            st;
  } cfl_res_t;

  typedef struct packed {
    elem_t    e;
    bit       typed;   // expectation typed in below, otherwise predicted
    cfl_res_t r;
  } row_t;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_wr_en = 0;
  logic [HTS_W-1:0]      cfg_wr_data = '0;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;   // density .. pos_right, density lowest
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;        // cfl_value, zero pad
  logic [STAT_W-1:0]     m_tuser;        // status

  euler_cfl_number dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor copy of the register
  logic [HTS_W-1:0] hts_model = '0;
  cfl_res_t pending_cfl[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  n_sent = 0, n_recv = 0;
  int  n_stat[4] = '{0, 0, 0, 0};
  longint cycles = 0;

  // CFL number of one element, exact integer arithmetic
  function automatic cfl_res_t predict_cfl(elem_t e);
    longint rho, mom, ene, dxp, dxn, dx, d;
    longint unsigned am, ke, p, u;
    bit [127:0] c2, c, t, w, q;
    cfl_res_t r;
    rho = e.rho; mom = e.mom; ene = e.ene;
    dxp = longint'(e.xr) - longint'(e.xc);
    dxn = longint'(e.xc) - longint'(e.xl);
    dx  = dxp < dxn ? dxp : dxn;
    r.cfl = '0;
    r.st  = STAT_OK;
    if (rho <= 0) begin
      r.st = STAT_DENSITY;
      return r;
    end
    if (dx <= 0) begin
      r.st = STAT_SPACING;
      return r;
    end
    am = mom < 0 ? -mom : mom;
    ke = (am * am) / (2 * rho);
    d  = ene - longint'(ke);
    p  = d > 0 ? (2 * d) / 5 : 0;
    c2 = (128'(7 * p) << (2 * FB)) / 128'(5 * rho);
    c  = '0;
    for (int b = 41; b >= 0; b--) begin
      t = c | (128'd1 << b);
      if (t * t <= c2) c = t;
    end
    u = (am << FB) / rho;
    w = c + 128'(u);
    q = (128'(hts_model) * w) / 128'(dx);
    if (q > 128'(CFL_MAX)) begin
      r.cfl = CFL_MAX;
      r.st  = STAT_SATURATED;
    end else begin
      r.cfl = q[HTS_W-1:0];
    end
    return r;
  endfunction

  // scaled random magnitude so small and large values both show up
  function automatic logic signed [31:0] scaled_val(bit allow_neg);
    logic signed [31:0] v;
    v = $urandom >> $urandom_range(31, 1);
    if (allow_neg && $urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    int    sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      // noise: every bit of every field at random
      e = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return e;
    end
    e.rho = scaled_val(0) + 1;
    if (sel < 15) e.rho = -scaled_val(0);
    e.mom = scaled_val(1);
    e.ene = $urandom_range(9) == 0 ? scaled_val(1) : scaled_val(0);
    e.xc  = scaled_val(1);
    e.xr  = e.xc + scaled_val(0) + 1;
    e.xl  = e.xc - scaled_val(0) - 1;
    if (sel >= 15 && sel < 20) e.xr = e.xc - scaled_val(0);
    return e;
  endfunction

  task automatic write_hts(logic [HTS_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    hts_model    = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // hold the request until it is taken, then queue its expected result
  task automatic send_elem(elem_t e, bit typed, cfl_res_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {e.xr, e.xc, e.xl, e.ene, e.mom, e.rho};
    do @(posedge clk); while (!s_tready);
    pending_cfl.push_back(typed ? r : predict_cfl(e));
    n_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_cfl.size() != 0) @(posedge clk);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    cfl_res_t x;
    if (!rst && m_tvalid && m_tready) begin
      n_recv++;
      n_stat[m_tuser]++;
      if (pending_cfl.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cfl=%h status=%0d", $time, m_tdata[30:0], m_tuser);
      end else begin
        x = pending_cfl.pop_front();
        if (m_tdata[30:0] !== x.cfl) begin
          errors++;
          $display("%0t: cfl_value expected %h actual %h", $time, x.cfl, m_tdata[30:0]);
        end
        if (m_tuser !== x.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, x.st, m_tuser);
        end
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  // directed elements: rho, mom, ene, xl, xc, xr
  row_t dir_rows[] = '{
    '{'{0, 0, 0, 0, ONE, 2*ONE},          1, '{0, STAT_DENSITY}},
    '{'{SMIN, 5, 5, 0, ONE, 2*ONE},       1, '{0, STAT_DENSITY}},
    // density is checked before the spacing
    '{'{-1, 0, 0, 0, 0, 0},               1, '{0, STAT_DENSITY}},
    '{'{ONE, 0, ONE, 0, ONE, ONE},        1, '{0, STAT_SPACING}},
    '{'{ONE, 0, ONE, ONE, 0, ONE},        1, '{0, STAT_SPACING}},
    '{'{ONE, ONE, ONE, SMAX, SMIN, SMAX}, 1, '{0, STAT_SPACING}},
    // tiny density, huge momentum, unit spacing: saturates
    '{'{1, SMAX, SMAX, 0, 1, 2},          1, '{CFL_MAX, STAT_SATURATED}},
    // at rest with no pressure: zero CFL, no flag
    '{'{ONE, 0, -ONE, 0, ONE, 2*ONE},     1, '{0, STAT_OK}},
    '{'{ONE, 0, 163840, 0, 32768, ONE},   0, '{0, STAT_OK}},
    '{'{ONE, ONE, 163840, -ONE, 0, ONE},  0, '{0, STAT_OK}},
    '{'{ONE, -ONE, 163840, -ONE, 0, ONE}, 0, '{0, STAT_OK}},
    '{'{SMAX, SMIN, SMAX, SMIN, 0, SMAX}, 0, '{0, STAT_OK}},
    '{'{SMAX, SMAX, SMAX, 0, 1, 3},       0, '{0, STAT_OK}},
    '{'{SMAX, 0, SMIN, 0, ONE, 2*ONE},    0, '{0, STAT_OK}},
    '{'{1, 0, 1, 0, ONE, 2*ONE},          0, '{0, STAT_OK}},
    '{'{1, 0, SMAX, 0, SMAX/2, SMAX},     0, '{0, STAT_OK}},
    '{'{ONE, SMIN, SMAX, 0, ONE, 3*ONE},  0, '{0, STAT_OK}},
    '{'{2*ONE, 3*ONE, 10*ONE, 0, 100, 300}, 0, '{0, STAT_OK}},
    '{'{ONE/2, -5*ONE, 50*ONE, -7, 0, 9}, 0, '{0, STAT_OK}}
  };

  initial begin
    logic [HTS_W-1:0] hts_plan[6];
    int idle_plan[6][2];
    cfl_res_t none;
    none = '{0, STAT_OK};
    hts_plan  = '{0, 1, HTS_W'(ONE), CFL_MAX, 31'($urandom), 31'($urandom_range(4096))};
    idle_plan = '{'{0, 0}, '{85, 0}, '{0, 85}, '{15, 15}, '{0, 0}, '{85, 0}};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at the largest time step
    write_hts(CFL_MAX);
    foreach (dir_rows[i]) send_elem(dir_rows[i].e, dir_rows[i].typed, dir_rows[i].r);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_hts(hts_plan[ph]);
      send_idle_pct  = idle_plan[ph][0];
      recv_stall_pct = idle_plan[ph][1];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_elem(rand_elem(), 0, none);
        // drain completely once mid-phase before carrying on
        if (ph == 4 && i == PHASE_ITEMS / 2) wait_idle();
      end
      wait_idle();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYC) @(posedge clk);
    $display("sent %0d elements, got %0d results over 6 time-step settings", n_sent, n_recv);
    $display("status counts ok/density/spacing/saturated: %0d/%0d/%0d/%0d",
             n_stat[0], n_stat[1], n_stat[2], n_stat[3]);
    if (errors == 0 && pending_cfl.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ecfl_pkg.sv
rtl/ecfl_div.sv
rtl/ecfl_sqrt.sv
rtl/ecfl_skid.sv
rtl/euler_cfl_number.sv
bench/tb_euler_cfl_number.sv
